// File: rtl/assert_macros.svh
// Assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ppmfd_pkg.sv
// Constants and codes for the PPM sensor frame decoder.
package ppmfd_pkg;

    localparam int DUR_W      = 16;
    localparam int TOL_W      = 7;
    localparam int FRAME_BITS = 36;
    localparam int HUNT_LIMIT = 10;
    localparam int HUNT_W     = 4;
    localparam int BITPOS_W   = 6;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int ID_W       = 8;
    localparam int CHAN_W     = 3;
    localparam int TEMP_W     = 12;
    localparam int HUM_W      = 8;

    // d * 100 and nominal * (100 +/- tol) widths
    localparam int DUR100_W   = 23;
    localparam int PROD_W     = 24;

    // Register indices (byte address = 4 * index)
    localparam logic [2:0] REG_PULSE = 3'd0;
    localparam logic [2:0] REG_SHORT = 3'd1;
    localparam logic [2:0] REG_LONG  = 3'd2;
    localparam logic [2:0] REG_SYNC  = 3'd3;
    localparam logic [2:0] REG_TOL   = 3'd4;

    // Register reset values
    localparam logic [DUR_W-1:0] PULSE_RST = 16'd500;
    localparam logic [DUR_W-1:0] SHORT_RST = 16'd1000;
    localparam logic [DUR_W-1:0] LONG_RST  = 16'd2000;
    localparam logic [DUR_W-1:0] SYNC_RST  = 16'd4000;
    localparam logic [TOL_W-1:0] TOL_RST   = 7'd25;
    localparam logic [TOL_W-1:0] TOL_MAX   = 7'd100;

    // Decoder phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUNT = 2'd1;
    localparam logic [1:0] PH_BITS = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SYNC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BIT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_NIB = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_ID = 3'd4;

    localparam logic [3:0] CONST_NIBBLE = 4'hF;

endpackage

// File: rtl/ppm_sensor_frame_decoder.sv
// PPM sensor frame decoder: tolerance matching, sync hunt, 36-bit frame assembly and check.
//
// One mark/space pair is taken per clock whenever result_ready (or an empty result
// register) lets the pipeline move, so pairs can arrive back to back. A pair is accepted
// into the input register, then matched and decoded by combinational logic, and the
// result register loads at the next edge at which the pipeline moves, and a
// waiting result can hold the pipeline. At most one result is given per burst. Durations
// are matched without a divider: a value d lies in
// [floor(N*(100-t)/100), floor(N*(100+t)/100)] exactly when 100*d+99 >= N*(100-t) and
// 100*d <= N*(100+t), so the eight nominal*factor products are rebuilt from the
// configuration registers into flip-flops every cycle and each pair only needs a
// constant multiply by 100 and two compares per nominal. A tolerance above 100 is
// treated as 100. Configuration goes through the APB port (pready always high) and
// should be written only while no transaction is in flight; a pair may follow from the
// edge after the write.
`include "assert_macros.svh"

module ppm_sensor_frame_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ppmfd_pkg::ADDR_W-1:0]          paddr,
    input  logic [ppmfd_pkg::DATA_W-1:0]          pwdata,
    output logic [ppmfd_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready,
    // pair channel
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [ppmfd_pkg::DUR_W-1:0]           mark_us,
    input  logic [ppmfd_pkg::DUR_W-1:0]           space_us,
    input  logic                                  burst_first,
    input  logic                                  burst_last,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [ppmfd_pkg::STATUS_W-1:0]        status,
    output logic [ppmfd_pkg::ID_W-1:0]            sensor_id,
    output logic                                  battery_good,
    output logic                                  test_flag,
    output logic [ppmfd_pkg::CHAN_W-1:0]          channel_number,
    output logic signed [ppmfd_pkg::TEMP_W-1:0]   temperature_tenths,
    output logic [ppmfd_pkg::HUM_W-1:0]           humidity_percent
);
    import ppmfd_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DUR_W-1:0] pulse_nom_reg;
    logic [DUR_W-1:0] short_nom_reg;
    logic [DUR_W-1:0] long_nom_reg;
    logic [DUR_W-1:0] sync_nom_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_nom_reg <= PULSE_RST;
            short_nom_reg <= SHORT_RST;
            long_nom_reg  <= LONG_RST;
            sync_nom_reg  <= SYNC_RST;
            tol_reg       <= TOL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_PULSE: pulse_nom_reg <= pwdata[DUR_W-1:0];
                REG_SHORT: short_nom_reg <= pwdata[DUR_W-1:0];
                REG_LONG:  long_nom_reg  <= pwdata[DUR_W-1:0];
                REG_SYNC:  sync_nom_reg  <= pwdata[DUR_W-1:0];
                REG_TOL:   tol_reg       <= pwdata[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_PULSE: prdata = DATA_W'(pulse_nom_reg);
            REG_SHORT: prdata = DATA_W'(short_nom_reg);
            REG_LONG:  prdata = DATA_W'(long_nom_reg);
            REG_SYNC:  prdata = DATA_W'(sync_nom_reg);
            REG_TOL:   prdata = DATA_W'(tol_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- tolerance bounds, scaled by 100 ----------------
    logic [TOL_W-1:0]  tol_clamped;
    logic [TOL_W-1:0]  lo_factor;
    logic [7:0]        hi_factor;
    logic [PROD_W-1:0] pulse_lo_reg, pulse_hi_reg;
    logic [PROD_W-1:0] short_lo_reg, short_hi_reg;
    logic [PROD_W-1:0] long_lo_reg,  long_hi_reg;
    logic [PROD_W-1:0] sync_lo_reg,  sync_hi_reg;

    assign tol_clamped = (tol_reg > TOL_MAX) ? TOL_MAX : tol_reg;
    assign lo_factor   = TOL_MAX - tol_clamped;
    assign hi_factor   = 8'(TOL_MAX) + 8'(tol_clamped);

    always_ff @(posedge clk)
    begin
        pulse_lo_reg <= PROD_W'(pulse_nom_reg) * PROD_W'(lo_factor);
        pulse_hi_reg <= PROD_W'(pulse_nom_reg) * PROD_W'(hi_factor);
        short_lo_reg <= PROD_W'(short_nom_reg) * PROD_W'(lo_factor);
        short_hi_reg <= PROD_W'(short_nom_reg) * PROD_W'(hi_factor);
        long_lo_reg  <= PROD_W'(long_nom_reg)  * PROD_W'(lo_factor);
        long_hi_reg  <= PROD_W'(long_nom_reg)  * PROD_W'(hi_factor);
        sync_lo_reg  <= PROD_W'(sync_nom_reg)  * PROD_W'(lo_factor);
        sync_hi_reg  <= PROD_W'(sync_nom_reg)  * PROD_W'(hi_factor);
    end

    // ---------------- pipeline control ----------------
    // Whole pipeline moves together; the result register decouples the two sides.
    logic advance;
    logic result_valid_reg;

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;

    // ---------------- input register, durations times 100 ----------------
    logic                s1_valid_reg;
    logic [DUR100_W-1:0] s1_mark100_reg;
    logic [DUR100_W-1:0] s1_space100_reg;
    logic                s1_first_reg;
    logic                s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mark100_reg  <= DUR100_W'(mark_us) * DUR100_W'(100);
            s1_space100_reg <= DUR100_W'(space_us) * DUR100_W'(100);
            s1_first_reg    <= burst_first;
            s1_last_reg     <= burst_last;
        end
    end

    // ---------------- range matches ----------------
    logic [PROD_W-1:0] mark_up, mark_dn, space_up, space_dn;
    logic              mark_ok, short_ok, long_ok, sync_ok;

    assign mark_dn  = PROD_W'(s1_mark100_reg);
    assign mark_up  = PROD_W'(s1_mark100_reg) + PROD_W'(99);
    assign space_dn = PROD_W'(s1_space100_reg);
    assign space_up = PROD_W'(s1_space100_reg) + PROD_W'(99);

    assign mark_ok  = (pulse_lo_reg <= mark_up)  && (mark_dn  <= pulse_hi_reg);
    assign short_ok = (short_lo_reg <= space_up) && (space_dn <= short_hi_reg);
    assign long_ok  = (long_lo_reg  <= space_up) && (space_dn <= long_hi_reg);
    assign sync_ok  = (sync_lo_reg  <= space_up) && (space_dn <= sync_hi_reg);

    // ---------------- decoder state and result ----------------
    logic [1:0]            phase_reg, phase_next;
    logic [HUNT_W-1:0]     hunt_reg, hunt_next;
    logic [BITPOS_W-1:0]   bitpos_reg, bitpos_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;

    logic                  is_sync, is_short, is_long;
    logic                  bit_ok, bit_val;
    logic                  emit;
    logic [STATUS_W-1:0]   st;
    logic [ID_W-1:0]       id_v;
    logic                  batt_v, test_v;
    logic [CHAN_W-1:0]     chan_v;
    logic [TEMP_W-1:0]     temp_v;
    logic [HUM_W-1:0]      hum_v;

    assign is_sync  = mark_ok & sync_ok;
    assign is_short = mark_ok & short_ok;
    assign is_long  = mark_ok & long_ok;

    always_comb
    begin
        phase_next  = phase_reg;
        hunt_next   = hunt_reg;
        bitpos_next = bitpos_reg;
        frame_next  = frame_reg;
        bit_ok      = 1'b1;
        bit_val     = 1'b0;
        emit        = 1'b0;
        st          = ST_OK;
        id_v        = '0;
        batt_v      = 1'b0;
        test_v      = 1'b0;
        chan_v      = '0;
        temp_v      = '0;
        hum_v       = '0;

        if (s1_first_reg)
        begin
            phase_next  = PH_HUNT;
            hunt_next   = '0;
            bitpos_next = BITPOS_W'(FRAME_BITS - 1);
            frame_next  = '0;
        end

        unique case (phase_next)
            PH_HUNT:
            begin
                if (is_sync)
                begin
                    phase_next = PH_BITS;
                end
                else if (is_short || is_long)
                begin
                    hunt_next = hunt_next + HUNT_W'(1);
                    if (hunt_next >= HUNT_W'(HUNT_LIMIT))
                    begin
                        emit = 1'b1;
                        st   = ST_NO_SYNC;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    st   = ST_NO_SYNC;
                end
                // burst ended before any frame bit
                if (!emit && s1_last_reg)
                begin
                    emit = 1'b1;
                    st   = (phase_next == PH_BITS) ? ST_BAD_BIT : ST_NO_SYNC;
                end
            end
            PH_BITS:
            begin
                // long gap tested first; final bit accepts any gap
                if (is_long)
                begin
                    bit_val = 1'b1;
                end
                else if (is_short)
                begin
                    bit_val = 1'b0;
                end
                else if (bitpos_next == '0 && mark_ok)
                begin
                    bit_val = 1'b0;
                end
                else
                begin
                    bit_ok = 1'b0;
                end

                if (!bit_ok)
                begin
                    emit = 1'b1;
                    st   = ST_BAD_BIT;
                end
                else
                begin
                    frame_next = {frame_next[FRAME_BITS-2:0], bit_val};
                    if (bitpos_next == '0)
                    begin
                        emit = 1'b1;
                        if (frame_next[11:8] != CONST_NIBBLE)
                        begin
                            st = ST_BAD_NIB;
                        end
                        else if (frame_next[35:28] == '0)
                        begin
                            st = ST_ZERO_ID;
                        end
                        else
                        begin
                            st     = ST_OK;
                            id_v   = frame_next[35:28];
                            batt_v = frame_next[27];
                            test_v = frame_next[26];
                            chan_v = CHAN_W'(frame_next[25:24]) + CHAN_W'(1);
                            temp_v = frame_next[23:12];
                            hum_v  = frame_next[7:0];
                        end
                    end
                    else
                    begin
                        bitpos_next = bitpos_next - BITPOS_W'(1);
                        if (s1_last_reg)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_BIT;
                        end
                    end
                end
            end
            PH_IDLE, PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            hunt_reg         <= '0;
            bitpos_reg       <= BITPOS_W'(FRAME_BITS - 1);
            frame_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s1_valid_reg & emit;
            if (s1_valid_reg)
            begin
                phase_reg  <= phase_next;
                hunt_reg   <= hunt_next;
                bitpos_reg <= bitpos_next;
                frame_reg  <= frame_next;
            end
        end
    end

    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     id_reg;
    logic                batt_reg, test_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [HUM_W-1:0]    hum_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= st;
            id_reg     <= id_v;
            batt_reg   <= batt_v;
            test_reg   <= test_v;
            chan_reg   <= chan_v;
            temp_reg   <= temp_v;
            hum_reg    <= hum_v;
        end
    end

    assign result_valid       = result_valid_reg;
    assign status             = status_reg;
    assign sensor_id          = id_reg;
    assign battery_good       = batt_reg;
    assign test_flag          = test_reg;
    assign channel_number     = chan_reg;
    assign temperature_tenths = signed'(temp_reg);
    assign humidity_percent   = hum_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_fail_fields_zero, result_valid && status != ST_OK,
        sensor_id == '0 && !battery_good && !test_flag && channel_number == '0 &&
        temperature_tenths == '0 && humidity_percent == '0)
    `ASSERT_IMPLIES(a_ok_has_id_and_channel, result_valid && status == ST_OK,
        sensor_id != '0 && channel_number != '0)
    `ASSERT_IMPLIES(a_hunt_below_limit, phase_reg == PH_HUNT,
        hunt_reg < HUNT_W'(HUNT_LIMIT))
    `ASSERT_NEXT(a_result_only_from_pair, !s1_valid_reg && advance, !result_valid)

endmodule
